>>> rtl/brd_pkg.sv
// Burst rate detector package: shared widths, register indexes, reset values
// and the operation codes of the shared arithmetic unit.
// No dependencies.
package brd_pkg;

    // Fixed field widths
    localparam int SID_IN_W   = 6;
    localparam int CNT_W      = 32;
    localparam int TIME_W     = 64;
    localparam int FACTOR_W   = 8;
    localparam int RUN_W      = 8;
    localparam int SUM_OUT_W  = 35;
    localparam int NZ_OUT_W   = 4;
    localparam int ALU_W      = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BURST_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_REQUIRED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 2'd2;

    localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 8'd48;
    localparam logic [RUN_W-1:0]      RUN_REQ_RST  = 8'd3;
    localparam logic [CFG_DATA_W-1:0] COOLDOWN_RST = 32'd10000;

    localparam logic [RUN_W-1:0]      RUN_MAX      = 8'd255;

    // Parameter defaults
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int STREAMS_DEF      = 64;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

endpackage

>>> rtl/brd_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module brd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/brd_alu.sv
// Shared arithmetic unit: 64-bit add, subtract with borrow, narrow multiply.
// Depends on brd_pkg.
module brd_alu
    import brd_pkg::*;
#(
    parameter int MUL_A_W = 35
) (
    input  t_alu_op          i_op,
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output logic [ALU_W-1:0] o_y,
    output logic             o_borrow
);

    logic [ALU_W:0]                  diff;
    logic [MUL_A_W+FACTOR_W-1:0]     prod;

    // Subtract with borrow out, multiply on the low operand bits
    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign prod = i_a[MUL_A_W-1:0] * i_b[FACTOR_W-1:0];

    always_comb begin
        o_borrow = diff[ALU_W];
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = diff[ALU_W-1:0];
            ALU_MUL: o_y = ALU_W'(prod);
            default: o_y = '0;
        endcase
    end

endmodule

>>> rtl/burst_rate_detector.sv
// Burst rate detector top level: sequencer, window and stream RAMs, shared unit.
// The window sum walks the RAM read port one entry per cycle through one adder.
// One item at a time: no new item is taken while one is in work.
// Reset: synchronous; then a clear pass zeroes every per-stream state entry before input is taken.
// Depends on brd_pkg, brd_ram, brd_alu.
module burst_rate_detector
    import brd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int STREAMS      = STREAMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SID_IN_W-1:0]   i_stream_id,
    input  logic [CNT_W-1:0]      i_interval_count,
    input  logic [TIME_W-1:0]     i_now_ms,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_alert,
    output logic                  o_burst_seen,
    output logic [CNT_W-1:0]      o_latest_count,
    output logic [SUM_OUT_W-1:0]  o_window_sum,
    output logic [NZ_OUT_W-1:0]   o_nonzero_entries,
    output logic [RUN_W-1:0]      o_run_length,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW       = $clog2(WINDOW_DEPTH);
    localparam int CW       = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW     = CNT_W + $clog2(WINDOW_DEPTH);
    localparam int SIDW     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int WIN_AW   = SIDW + IW;
    localparam int WIN_DEP  = STREAMS * (2 ** IW);
    localparam int LAST_LSB = 0;
    localparam int RUN_LSB  = TIME_W;
    localparam int SLOT_LSB = TIME_W + RUN_W;
    localparam int FULL_BIT = SLOT_LSB + IW;
    localparam int STW      = FULL_BIT + 1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_STATE,
        S_SUM,
        S_MULA,
        S_MULB,
        S_CMP,
        S_COOL,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [FACTOR_W-1:0]   r_factor;
    logic [RUN_W-1:0]      r_run_req;
    logic [CFG_DATA_W-1:0] r_cooldown;

    // Work registers
    logic [SIDW-1:0]   r_clr_idx;
    logic [SIDW-1:0]   r_sid;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_now;
    logic [IW-1:0]     r_slot;
    logic              r_full;
    logic [RUN_W-1:0]  r_run;
    logic [TIME_W-1:0] r_last;
    logic [ALU_W-1:0]  r_elapsed;
    logic [IW-1:0]     r_idx;
    logic [SUMW-1:0]   r_sum;
    logic [CW-1:0]     r_nz;
    logic [ALU_W-1:0]  r_prod;
    logic [ALU_W-1:0]  r_tmp;
    logic              r_burst;
    logic              r_fire;

    // Stream id folding table, built at elaboration
    logic [SIDW-1:0] sid_map [2**SID_IN_W];
    for (genvar g = 0; g < 2**SID_IN_W; g++) begin : g_sid
        assign sid_map[g] = SIDW'(g % STREAMS);
    end

    // RAM interfaces
    logic              st_we;
    logic [SIDW-1:0]   st_waddr;
    logic [STW-1:0]    st_wdata;
    logic [SIDW-1:0]   st_raddr;
    logic [STW-1:0]    st_rdata;
    logic              win_we;
    logic [WIN_AW-1:0] win_waddr;
    logic [WIN_AW-1:0] win_raddr;
    logic [CNT_W-1:0]  win_rdata;
    logic [CNT_W-1:0]  win_val;

    // Shared unit interface
    t_alu_op          alu_op;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic [ALU_W-1:0] alu_y;
    logic             alu_borrow;

    logic             in_acc;
    logic             out_free;
    logic             last_entry;
    logic             slot_wrap;
    logic [IW-1:0]    slot_nx;
    logic [RUN_W-1:0] run_burst;
    logic             fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !o_out_valid || i_out_ready;
    assign last_entry  = (r_idx == IW'(WINDOW_DEPTH - 1));
    assign slot_wrap   = (r_slot == IW'(WINDOW_DEPTH - 1));
    assign slot_nx     = slot_wrap ? '0 : IW'(r_slot + 1'b1);

    // Saturating run step on a burst, clear otherwise
    assign run_burst = alu_borrow ? ((r_run == RUN_MAX) ? RUN_MAX : RUN_W'(r_run + 1'b1))
                                  : '0;
    assign fire      = !alu_borrow && (r_run >= r_run_req);

    // Window entry in scan: the new count at its slot, unwritten slots read as zero
    always_comb begin
        if (r_idx == r_slot) begin
            win_val = r_cnt;
        end else if (r_full || (r_idx < r_slot)) begin
            win_val = win_rdata;
        end else begin
            win_val = '0;
        end
    end

    // Stream state RAM: clear pass, read on accept, write back at the end
    assign st_raddr = sid_map[i_stream_id];
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_sid;
        st_wdata = {slot_wrap | r_full, slot_nx, r_run, r_last};
        if (r_state == S_CLR) begin
            st_we    = 1'b1;
            st_waddr = r_clr_idx;
            st_wdata = '0;
        end else if (r_state == S_DONE && out_free) begin
            st_we    = 1'b1;
        end
    end

    // Window RAM: store the new count, then scan from entry zero
    assign win_we    = (r_state == S_STATE);
    assign win_waddr = {r_sid, st_rdata[SLOT_LSB +: IW]};
    assign win_raddr = (r_state == S_STATE) ? {r_sid, IW'(0)}
                                            : {r_sid, IW'(r_idx + 1'b1)};

    // Operand selection for the shared unit
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            S_STATE: begin
                alu_a = r_now;
                alu_b = st_rdata[LAST_LSB +: TIME_W];
            end
            S_SUM: begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(r_sum);
                alu_b  = ALU_W'(win_val);
            end
            S_MULA: begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(r_cnt);
                alu_b  = ALU_W'(r_nz);
            end
            S_MULB: begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(r_sum);
                alu_b  = ALU_W'(r_factor);
            end
            S_CMP: begin
                alu_a = r_tmp;
                alu_b = r_prod;
            end
            S_COOL: begin
                alu_a = r_elapsed;
                alu_b = ALU_W'(r_cooldown);
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_clr_idx == SIDW'(STREAMS - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_STATE;
            S_STATE: n_state = S_SUM;
            S_SUM:   if (last_entry) n_state = S_MULA;
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_CMP;
            S_CMP:   n_state = S_COOL;
            S_COOL:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State, work registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            o_out_valid <= 1'b0;
            r_factor    <= FACTOR_RST;
            r_run_req   <= RUN_REQ_RST;
            r_cooldown  <= COOLDOWN_RST;
        end else begin
            r_state <= n_state;

            // configuration transaction
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BURST_FACTOR: r_factor   <= i_cfg_data[FACTOR_W-1:0];
                    CFG_RUN_REQUIRED: r_run_req  <= i_cfg_data[RUN_W-1:0];
                    CFG_COOLDOWN:     r_cooldown <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop result once taken, unless a new one replaces it
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr_idx <= SIDW'(r_clr_idx + 1'b1);
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_sid <= sid_map[i_stream_id];
                        r_cnt <= i_interval_count;
                        r_now <= i_now_ms;
                    end
                end
                S_STATE: begin
                    r_slot    <= st_rdata[SLOT_LSB +: IW];
                    r_full    <= st_rdata[FULL_BIT];
                    r_run     <= st_rdata[RUN_LSB +: RUN_W];
                    r_last    <= st_rdata[LAST_LSB +: TIME_W];
                    r_elapsed <= alu_y;
                    r_idx     <= '0;
                    r_sum     <= '0;
                    r_nz      <= '0;
                end
                S_SUM: begin
                    r_sum <= SUMW'(alu_y);
                    r_nz  <= CW'(r_nz + CW'(win_val != '0));
                    r_idx <= IW'(r_idx + 1'b1);
                end
                S_MULA: begin
                    r_prod <= {alu_y[ALU_W-5:0], 4'b0000};
                end
                S_MULB: begin
                    r_tmp <= alu_y;
                end
                S_CMP: begin
                    r_burst <= alu_borrow;
                    r_run   <= run_burst;
                end
                S_COOL: begin
                    r_fire <= fire;
                    if (fire) begin
                        r_run  <= '0;
                        r_last <= r_now;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid       <= 1'b1;
                        o_alert           <= r_fire;
                        o_burst_seen      <= r_burst;
                        o_latest_count    <= r_cnt;
                        o_window_sum      <= SUM_OUT_W'(r_sum);
                        o_nonzero_entries <= NZ_OUT_W'(r_nz);
                        o_run_length      <= r_run;
                    end
                end
                default: ;
            endcase
        end
    end

    brd_ram #(
        .WIDTH (STW),
        .DEPTH (STREAMS),
        .AW    (SIDW)
    ) u_stream_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    brd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (WIN_DEP),
        .AW    (WIN_AW)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (r_cnt),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    brd_alu #(
        .MUL_A_W (SUMW)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

endmodule

>>> rtl/brd_checker.sv
// Port-level checks for the burst rate detector, attached by bind.
// Depends on brd_pkg and the burst_rate_detector ports.
module brd_checker
    import brd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_alert,
    input logic                 o_burst_seen,
    input logic [CNT_W-1:0]     o_latest_count,
    input logic [RUN_W-1:0]     o_run_length
);

    // One item at a time: ready drops after an input transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after a transaction");

    // Firing clears the run
    a_alert_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alert |-> o_run_length == '0)
        else $error("alert reported with a nonzero run");

    // A quiet interval leaves no run behind
    a_quiet_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_burst_seen |-> o_run_length == '0)
        else $error("run kept across a non-burst interval");

    // A burst needs a nonzero count
    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_burst_seen |-> o_latest_count != '0)
        else $error("burst reported for an empty interval");

    // Stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_latest_count))
        else $error("result changed while stalled");

endmodule

bind burst_rate_detector brd_checker u_brd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_alert        (o_alert),
    .o_burst_seen   (o_burst_seen),
    .o_latest_count (o_latest_count),
    .o_run_length   (o_run_length)
);

>>> test/burst_rate_detector_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for burst_rate_detector: directed table, then randomized phases.
// Predicts results from its own window model, or takes a typed row's result; depends on brd_pkg and the RTL.
module burst_rate_detector_tb;
    import brd_pkg::*;

    localparam int WIN   = WINDOW_DEPTH_DEF;
    localparam int NSTRM = STREAMS_DEF;

    typedef struct packed {
        logic                 alert;
        logic                 burst;
        logic [CNT_W-1:0]     latest;
        logic [SUM_OUT_W-1:0] sum;
        logic [NZ_OUT_W-1:0]  nz;
        logic [RUN_W-1:0]     run;
    } t_interval_result;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [SID_IN_W-1:0]   sid;
        logic [CNT_W-1:0]      cnt;
        logic [TIME_W-1:0]     now;
        logic                  typed;
        t_interval_result      want;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SID_IN_W-1:0]   i_stream_id;
    logic [CNT_W-1:0]      i_interval_count;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_alert;
    logic                  o_burst_seen;
    logic [CNT_W-1:0]      o_latest_count;
    logic [SUM_OUT_W-1:0]  o_window_sum;
    logic [NZ_OUT_W-1:0]   o_nonzero_entries;
    logic [RUN_W-1:0]      o_run_length;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted per-stream state and register copies
    logic [CNT_W-1:0]      win_count [NSTRM][WIN];
    int unsigned           ring_pos  [NSTRM];
    logic [RUN_W-1:0]      run_len   [NSTRM];
    logic [TIME_W-1:0]     last_fire [NSTRM];
    logic [FACTOR_W-1:0]   cfg_factor;
    logic [RUN_W-1:0]      run_needed;
    logic [CFG_DATA_W-1:0] cooldown_span;

    t_interval_result pending_results [$];
    t_directed_row    directed_rows [$];
    int               mismatch_count = 0;
    int               items_sent = 0;
    int               burst_left = 0;
    logic [TIME_W-1:0] now_clock = '0;
    logic [SID_IN_W-1:0] hot_sid [4];

    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    logic [15:0] stall_bits = 16'hFFFF;

    burst_rate_detector i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_stream_id       (i_stream_id),
        .i_interval_count  (i_interval_count),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_alert           (o_alert),
        .o_burst_seen      (o_burst_seen),
        .o_latest_count    (o_latest_count),
        .o_window_sum      (o_window_sum),
        .o_nonzero_entries (o_nonzero_entries),
        .o_run_length      (o_run_length),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Record one interval count and work out the resulting detector outputs
    function automatic t_interval_result predict_interval(input logic [SID_IN_W-1:0] sid,
                                                          input logic [CNT_W-1:0] cnt,
                                                          input logic [TIME_W-1:0] now);
        logic [63:0]         sum;
        logic [NZ_OUT_W-1:0] nz;
        logic [63:0]         lhs;
        logic [63:0]         rhs;
        logic                burst;
        logic                fire;
        int                  k;
        win_count[sid][ring_pos[sid]] = cnt;
        ring_pos[sid] = (ring_pos[sid] + 1) % WIN;
        sum = '0;
        nz  = '0;
        for (k = 0; k < WIN; k++) begin
            if (win_count[sid][k] != '0) begin
                sum = sum + {32'h0, win_count[sid][k]};
                nz  = nz + 1'b1;
            end
        end
        lhs   = {32'h0, cnt} * {60'h0, nz} * 64'd16;
        rhs   = sum * {56'h0, cfg_factor};
        burst = lhs > rhs;
        // Saturating run of consecutive bursts; a quiet interval clears it
        if (burst) begin
            if (run_len[sid] != RUN_MAX)
                run_len[sid] = run_len[sid] + 1'b1;
        end else begin
            run_len[sid] = '0;
        end
        // Elapsed time wraps modulo 2^64
        fire = 1'b0;
        if (run_len[sid] >= run_needed && (now - last_fire[sid]) >= {32'h0, cooldown_span}) begin
            fire           = 1'b1;
            last_fire[sid] = now;
            run_len[sid]   = '0;
        end
        return {fire, burst, cnt, sum[SUM_OUT_W-1:0], nz, run_len[sid]};
    endfunction

    function automatic logic [TIME_W-1:0] next_time();
        if ($urandom_range(0, 29) == 0)
            now_clock = {$urandom, $urandom};
        else
            now_clock = now_clock + $urandom_range(0, 2500);
        return now_clock;
    endfunction

    // Sender bursts: random length, separated by random gaps (sometimes none)
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_interval(input logic [SID_IN_W-1:0] sid, input logic [CNT_W-1:0] cnt,
                                 input logic [TIME_W-1:0] now, input logic typed,
                                 input t_interval_result typed_res);
        t_interval_result res;
        pace_sender();
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_stream_id      <= sid;
        i_interval_count <= cnt;
        i_now_ms         <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = predict_interval(sid, cnt, now);
        pending_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // Hold off input until every outstanding result has drained
    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BURST_FACTOR: cfg_factor    = data[FACTOR_W-1:0];
            CFG_RUN_REQUIRED: run_needed    = data[RUN_W-1:0];
            CFG_COOLDOWN:     cooldown_span = data;
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Quiet baseline followed by an escalating ramp on one hot stream
    task automatic emit_sequence();
        logic [SID_IN_W-1:0] sid;
        logic [63:0]         level;
        logic [CNT_W-1:0]    cnt;
        int                  base_n;
        int                  ramp_n;
        int                  k;
        sid    = hot_sid[$urandom_range(0, 3)];
        base_n = $urandom_range(0, 8);
        ramp_n = $urandom_range(1, 6);
        level  = 64'($urandom_range(1, 64));
        for (k = 0; k < base_n; k++) begin
            cnt = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 64);
            send_interval(sid, cnt, next_time(), 1'b0, '0);
        end
        for (k = 0; k < ramp_n; k++) begin
            level = level * $urandom_range(2, 12);
            if (level > 64'hFFFF_FFFF)
                level = 64'hFFFF_FFFF;
            send_interval(sid, level[CNT_W-1:0], next_time(), 1'b0, '0);
        end
    endtask

    task automatic emit_noise();
        logic [SID_IN_W-1:0] sid;
        logic [CNT_W-1:0]    cnt;
        logic [TIME_W-1:0]   now;
        sid = SID_IN_W'($urandom_range(0, NSTRM - 1));
        cnt = $urandom >> $urandom_range(0, 31);
        now = $urandom_range(0, 1) ? {$urandom, $urandom} : now_clock - $urandom_range(0, 5000);
        send_interval(sid, cnt, now, 1'b0, '0);
    endtask

    // One register setting followed by its share of random traffic
    task automatic run_phase(input logic [FACTOR_W-1:0] factor, input logic [RUN_W-1:0] run_req,
                             input logic [CFG_DATA_W-1:0] cool, input int n,
                             input logic saturate);
        logic [SID_IN_W-1:0] sat_sid;
        logic [CNT_W-1:0]    sat_cnt;
        int                  target;
        int                  k;
        wait_idle();
        write_reg(CFG_BURST_FACTOR, {24'h0, factor});
        write_reg(CFG_RUN_REQUIRED, {24'h0, run_req});
        write_reg(CFG_COOLDOWN, cool);
        for (k = 0; k < 4; k++)
            hot_sid[k] = SID_IN_W'($urandom_range(0, NSTRM - 1));
        target = items_sent + n;
        if (saturate) begin
            // Constant count keeps bursting; time stays inside the cooldown
            sat_sid = SID_IN_W'($urandom_range(0, NSTRM - 1));
            sat_cnt = $urandom_range(1, 65535);
            for (k = 1; k <= n; k++)
                send_interval(sat_sid, sat_cnt, last_fire[sat_sid] + 64'(k), 1'b0, '0);
        end else begin
            while (items_sent < target) begin
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
                if ($urandom_range(0, 3) != 0)
                    emit_sequence();
                else
                    emit_noise();
            end
        end
    endtask

    task automatic add_row(input logic is_reg, input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input logic [SID_IN_W-1:0] sid,
                           input logic [CNT_W-1:0] cnt, input logic [TIME_W-1:0] now,
                           input logic typed, input t_interval_result want);
        t_directed_row row;
        row.is_reg   = is_reg;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.sid      = sid;
        row.cnt      = cnt;
        row.now      = now;
        row.typed    = typed;
        row.want     = want;
        directed_rows.push_back(row);
    endtask

    // Receiver stalls follow a rotating bit pattern; pattern and mode are redrawn when a random countdown runs out
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(16, 96);
            stall_mode <= $urandom_range(0, 3);
            stall_bits <= 16'($urandom);
        end else begin
            stall_left <= stall_left - 1;
            stall_bits <= {stall_bits[14:0], stall_bits[15]};
        end
        i_out_ready <= (stall_mode == 0) ? 1'b1 : stall_bits[0];
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_interval_result got;
        t_interval_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_alert, o_burst_seen, o_latest_count, o_window_sum, o_nonzero_entries,
                   o_run_length};
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result transaction at %0t", $realtime);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.alert !== want.alert || got.burst !== want.burst ||
                    got.latest !== want.latest || got.sum !== want.sum ||
                    got.nz !== want.nz || got.run !== want.run) begin
                    if (mismatch_count < 10)
                        $display({"mismatch at %0t: expected alert=%0d burst=%0d count=%0d ",
                                  "sum=%0d nz=%0d run=%0d, got alert=%0d burst=%0d count=%0d ",
                                  "sum=%0d nz=%0d run=%0d"}, $realtime,
                                 want.alert, want.burst, want.latest, want.sum, want.nz,
                                 want.run, got.alert, got.burst, got.latest, got.sum, got.nz,
                                 got.run);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("burst_rate_detector_tb failed");
        $finish;
    end

    initial begin : stimulus
        int s;
        int k;
        int p;
        logic [CFG_DATA_W-1:0] cool;
        t_directed_row row;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_stream_id      = '0;
        i_interval_count = '0;
        i_now_ms         = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_BURST_FACTOR;
        i_cfg_data       = '0;
        for (s = 0; s < NSTRM; s++) begin
            for (k = 0; k < WIN; k++)
                win_count[s][k] = '0;
            ring_pos[s]  = 0;
            run_len[s]   = '0;
            last_fire[s] = '0;
        end
        cfg_factor    = FACTOR_RST;
        run_needed    = RUN_REQ_RST;
        cooldown_span = COOLDOWN_RST;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed table, reset register values: empty window, widest counts and times
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd0, 32'd0, 64'd0, 1'b1,
                {1'b0, 1'b0, 32'd0, 35'd0, 4'd0, 8'd0});
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                {1'b0, 1'b0, 32'hFFFF_FFFF, 35'h0_FFFF_FFFF, 4'd1, 8'd0});
        for (k = 0; k < 6; k++)
            add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                {1'b0, 1'b0, 32'hFFFF_FFFF, 35'h7_FFFF_FFF8, 4'd8, 8'd0});
        // Three bursts in a row on a quiet stream fire the first alert
        for (k = 0; k < 3; k++)
            add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd1, 32'd1, 64'd20000, 1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd1, 32'd1000, 64'd20000, 1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd1, 32'd100000, 64'd20001, 1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd1, 32'd10000000, 64'd20002, 1'b0, '0);
        // Short cooldown across the time wrap: blocked while inside it, fires exactly on it
        add_row(1'b1, CFG_RUN_REQUIRED, 32'd1, '0, '0, '0, 1'b0, '0);
        add_row(1'b1, CFG_COOLDOWN, 32'd100, '0, '0, '0, 1'b0, '0);
        for (k = 0; k < 3; k++)
            add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd4, 32'd1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd4, 32'd100, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd4, 32'd10000, 64'h50, 1'b0, '0);
        add_row(1'b0, CFG_BURST_FACTOR, '0, 6'd4, 32'd1000000, 64'h54, 1'b0, '0);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.is_reg) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_interval(row.sid, row.cnt, row.now, row.typed, row.want);
            end
        end

        // Register extremes, saturation with a sub-unity factor, zero run requirement
        run_phase(8'd16, 8'd1, 32'd0, 180, 1'b0);
        run_phase(8'd255, 8'd255, 32'hFFFF_FFFF, 140, 1'b0);
        run_phase(8'd8, 8'd255, 32'hFFFF_FFFF, 270, 1'b1);
        run_phase(8'd40, 8'd0, 32'd500, 140, 1'b0);
        for (p = 0; p < 4; p++) begin
            case ($urandom_range(0, 2))
                0:       cool = $urandom_range(0, 2000);
                1:       cool = $urandom_range(0, 20000);
                default: cool = $urandom;
            endcase
            run_phase(FACTOR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(16, 255)
                                                            : $urandom_range(16, 80)),
                      RUN_W'($urandom_range(1, 5)), cool, 170, 1'b0);
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("burst_rate_detector_tb passed");
        else
            $display("burst_rate_detector_tb failed");
        $finish;
    end

endmodule
